/* sv/fjac_pkg.sv */
// ----------------------------------------------------------------------------
// fjac_pkg: shared types and constants
// Beat types, register indexes, rotation table and saturation for the
// fixed-point constraint Jacobian unit.
// ----------------------------------------------------------------------------
package fjac_pkg;

  // Width of every signed result field.
  localparam int VALUE_WIDTH     = 32;
  localparam int CORDIC_STEPS    = 16;
  localparam int STEPS_PER_STAGE = 4;
  // Width of the rotation datapath (x, y and the angle accumulator).
  localparam int CW              = 34;
  // Width of the intermediate value handed to the saturator.
  localparam int SAT_W           = 68;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int GAIN_W          = 31;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;

  localparam logic signed [CW-1:0] ATAN [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
  };

  localparam logic signed [SAT_W-1:0] SAT_MAX =
    (68'sd1 <<< (VALUE_WIDTH - 1)) - 68'sd1;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_MAX - 68'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANCHOR_X = 3'd0,
    CFG_ANCHOR_Y = 3'd1,
    CFG_TARGET_X = 3'd2,
    CFG_TARGET_Y = 3'd3,
    CFG_SPRING   = 3'd4,
    CFG_DAMPING  = 3'd5
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0] SPRING_RESET  = 31'd655360;
  localparam logic [GAIN_W-1:0] DAMPING_RESET = 31'd65536;

  typedef struct packed {
    logic signed [31:0] body_x;
    logic signed [31:0] body_y;
    logic signed [15:0] body_angle;
    logic signed [31:0] spin_rate;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] jac_x_angle;
    logic signed [VALUE_WIDTH-1:0] jac_y_angle;
    logic signed [VALUE_WIDTH-1:0] jdot_x_angle;
    logic signed [VALUE_WIDTH-1:0] jdot_y_angle;
    logic signed [VALUE_WIDTH-1:0] error_x;
    logic signed [VALUE_WIDTH-1:0] error_y;
    logic        [GAIN_W-1:0]      stiffness_out;
    logic        [GAIN_W-1:0]      damping_out;
  } out_beat_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  // Clamp a wide signed value to the result range.
  function automatic logic signed [VALUE_WIDTH-1:0] sat_value(
    input logic signed [SAT_W-1:0] v
  );
    logic signed [SAT_W-1:0] c;
    begin
      if (v > SAT_MAX) begin
        c = SAT_MAX;
      end else if (v < SAT_MIN) begin
        c = SAT_MIN;
      end else begin
        c = v;
      end
      return c[VALUE_WIDTH-1:0];
    end
  endfunction

endpackage

/* sv/fjac_cordic_stage.sv */
// ----------------------------------------------------------------------------
// fjac_cordic_stage: one registered slice of the rotation pipeline
// Runs a few consecutive rotation steps and registers x, y and the angle.
// ----------------------------------------------------------------------------
module fjac_cordic_stage #(
  parameter int FIRST_STEP = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  fjac_pkg::cordic_t cord_i,
  output fjac_pkg::cordic_t cord_o
);

  fjac_pkg::cordic_t cord_d;
  fjac_pkg::cordic_t cord_q;

  always_comb begin
    logic signed [fjac_pkg::CW-1:0] dx;
    logic signed [fjac_pkg::CW-1:0] dy;
    cord_d = cord_i;
    for (int k = 0; k < fjac_pkg::STEPS_PER_STAGE; k++) begin
      dx = cord_d.y >>> (FIRST_STEP + k);
      dy = cord_d.x >>> (FIRST_STEP + k);
      if (!cord_d.z[fjac_pkg::CW-1]) begin
        cord_d.x = cord_d.x - dx;
        cord_d.y = cord_d.y + dy;
        cord_d.z = cord_d.z - fjac_pkg::ATAN[FIRST_STEP + k];
      end else begin
        cord_d.x = cord_d.x + dx;
        cord_d.y = cord_d.y - dy;
        cord_d.z = cord_d.z + fjac_pkg::ATAN[FIRST_STEP + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord_q <= cord_d;
    end
  end

  assign cord_o = cord_q;

endmodule

/* sv/fixed_point_constraint_jacobian_unit.sv */
// ----------------------------------------------------------------------------
// fixed_point_constraint_jacobian_unit: anchor constraint Jacobian per body
// Rotates the local anchor by the body angle and gives the angle columns of
// the Jacobian and its time derivative, the position error and the gains.
// ----------------------------------------------------------------------------
// The unit takes one body state per cycle while the output side does not
// stall and returns one result beat for each. The ten register stages
// are: input capture, four rotation stages of four steps each, clamping and
// quadrant folding, the four anchor products, rounding of the rotated anchor,
// the spin-rate products together with the error sums, and the output
// register. Each stage has its own valid bit and loads whenever it is empty
// or its successor moves, so a stalled output keeps accepting beats until
// every stage holds one. Configuration registers are read directly by the
// stages and must only be written while no beat is in flight.
// ----------------------------------------------------------------------------
module fixed_point_constraint_jacobian_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fjac_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fjac_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  fjac_pkg::in_beat_t                   in_beat_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output fjac_pkg::out_beat_t                  out_beat_o
);

  localparam int NST = 10;

  // Configuration registers.
  logic signed [31:0]               anchor_x_q, anchor_y_q;
  logic signed [31:0]               target_x_q, target_y_q;
  logic [fjac_pkg::GAIN_W-1:0]      spring_q, damping_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_x_q <= '0;
      anchor_y_q <= '0;
      target_x_q <= '0;
      target_y_q <= '0;
      spring_q   <= fjac_pkg::SPRING_RESET;
      damping_q  <= fjac_pkg::DAMPING_RESET;
    end else if (cfg_we_i) begin
      case (fjac_pkg::cfg_idx_e'(cfg_idx_i))
        fjac_pkg::CFG_ANCHOR_X: anchor_x_q <= cfg_data_i;
        fjac_pkg::CFG_ANCHOR_Y: anchor_y_q <= cfg_data_i;
        fjac_pkg::CFG_TARGET_X: target_x_q <= cfg_data_i;
        fjac_pkg::CFG_TARGET_Y: target_y_q <= cfg_data_i;
        fjac_pkg::CFG_SPRING:   spring_q   <= cfg_data_i[fjac_pkg::GAIN_W-1:0];
        fjac_pkg::CFG_DAMPING:  damping_q  <= cfg_data_i[fjac_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain. A stage loads when it is empty or
  // when the stage after it moves on in the same cycle.
  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NST-1];

  // Side-band values that ride along with the rotation. Stage 0 is the
  // input capture; entries 1 to 7 follow the pipeline.
  logic signed [31:0] bx_q [8];
  logic signed [31:0] by_q [8];
  logic signed [31:0] w_q  [8];
  logic [1:0]         quad_q [5];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      bx_q[0]   <= in_beat_i.body_x;
      by_q[0]   <= in_beat_i.body_y;
      w_q[0]    <= in_beat_i.spin_rate;
      quad_q[0] <= in_beat_i.body_angle[15:14];
    end
    for (int k = 1; k < 8; k++) begin
      if (rdy[k]) begin
        bx_q[k] <= bx_q[k-1];
        by_q[k] <= by_q[k-1];
        w_q[k]  <= w_q[k-1];
      end
    end
    for (int k = 1; k < 5; k++) begin
      if (rdy[k]) begin
        quad_q[k] <= quad_q[k-1];
      end
    end
  end

  // Stage 0: start the rotation from the gain-corrected unit vector, with the
  // angle inside the quadrant scaled to 2^32 units per turn.
  fjac_pkg::cordic_t cord0_q;
  fjac_pkg::cordic_t cord_q [5];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      cord0_q.x <= fjac_pkg::CORDIC_GAIN;
      cord0_q.y <= '0;
      cord0_q.z <= {4'b0000, in_beat_i.body_angle[13:0], 16'h0000};
    end
  end

  assign cord_q[0] = cord0_q;

  // Stages 1 to 4: sixteen rotation steps, four per stage.
  for (genvar g = 0; g < 4; g++) begin : g_cordic
    fjac_cordic_stage #(
      .FIRST_STEP(g * fjac_pkg::STEPS_PER_STAGE)
    ) u_stage (
      .clk_i (clk_i),
      .en_i  (rdy[g+1]),
      .cord_i(cord_q[g]),
      .cord_o(cord_q[g+1])
    );
  end

  // Stage 5: clamp the rotation result to [0, 1.0] and fold in the quadrant.
  logic signed [fjac_pkg::CW-1:0] xc, yc;
  logic signed [31:0]             cos_d, sin_d, cos_q, sin_q;

  always_comb begin
    if (cord_q[4].x[fjac_pkg::CW-1]) begin
      xc = '0;
    end else if (cord_q[4].x > fjac_pkg::ONE_Q30) begin
      xc = fjac_pkg::ONE_Q30;
    end else begin
      xc = cord_q[4].x;
    end
    if (cord_q[4].y[fjac_pkg::CW-1]) begin
      yc = '0;
    end else if (cord_q[4].y > fjac_pkg::ONE_Q30) begin
      yc = fjac_pkg::ONE_Q30;
    end else begin
      yc = cord_q[4].y;
    end
    case (quad_q[4])
      2'd0: begin
        cos_d = xc[31:0];
        sin_d = yc[31:0];
      end
      2'd1: begin
        cos_d = -yc[31:0];
        sin_d = xc[31:0];
      end
      2'd2: begin
        cos_d = -xc[31:0];
        sin_d = -yc[31:0];
      end
      default: begin
        cos_d = yc[31:0];
        sin_d = -xc[31:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  // Stage 6: the four exact anchor products in Q18.46.
  logic signed [63:0] p_cx_q, p_sy_q, p_sx_q, p_cy_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      p_cx_q <= 64'(cos_q) * 64'(anchor_x_q);
      p_sy_q <= 64'(sin_q) * 64'(anchor_y_q);
      p_sx_q <= 64'(sin_q) * 64'(anchor_x_q);
      p_cy_q <= 64'(cos_q) * 64'(anchor_y_q);
    end
  end

  // Stage 7: combine and round the rotated anchor to Q16.16.
  logic signed [63:0] rx_sum, ry_sum;
  logic signed [33:0] rx_q, ry_q;

  always_comb begin
    rx_sum = (p_cx_q - p_sy_q + 64'sd536870912) >>> 30;
    ry_sum = (p_sx_q + p_cy_q + 64'sd536870912) >>> 30;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      rx_q <= rx_sum[33:0];
      ry_q <= ry_sum[33:0];
    end
  end

  // Stage 8: spin-rate products and position errors.
  logic signed [65:0] pwx_q, pwy_q;
  logic signed [35:0] ex_q, ey_q;
  logic signed [33:0] rx8_q, ry8_q;

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      pwx_q <= 66'(w_q[7]) * 66'(rx_q);
      pwy_q <= 66'(w_q[7]) * 66'(ry_q);
      ex_q  <= 36'(bx_q[7]) + 36'(rx_q) - 36'(target_x_q);
      ey_q  <= 36'(by_q[7]) + 36'(ry_q) - 36'(target_y_q);
      rx8_q <= rx_q;
      ry8_q <= ry_q;
    end
  end

  // Stage 9: round, negate and saturate into the output register.
  logic signed [fjac_pkg::SAT_W-1:0] jdx_w, jdy_w;
  fjac_pkg::out_beat_t               out_d, out_q;

  always_comb begin
    jdx_w = (-(fjac_pkg::SAT_W'(pwx_q)) + 68'sd32768) >>> 16;
    jdy_w = (-(fjac_pkg::SAT_W'(pwy_q)) + 68'sd32768) >>> 16;
    out_d.jac_x_angle   = fjac_pkg::sat_value(-(fjac_pkg::SAT_W'(ry8_q)));
    out_d.jac_y_angle   = fjac_pkg::sat_value(fjac_pkg::SAT_W'(rx8_q));
    out_d.jdot_x_angle  = fjac_pkg::sat_value(jdx_w);
    out_d.jdot_y_angle  = fjac_pkg::sat_value(jdy_w);
    out_d.error_x       = fjac_pkg::sat_value(fjac_pkg::SAT_W'(ex_q));
    out_d.error_y       = fjac_pkg::sat_value(fjac_pkg::SAT_W'(ey_q));
    out_d.stiffness_out = spring_q;
    out_d.damping_out   = damping_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[9]) begin
      out_q <= out_d;
    end
  end

  assign out_beat_o = out_q;

endmodule

/* sv/fjac_checker.sv */
// ----------------------------------------------------------------------------
// fjac_checker: port-level checks for the constraint Jacobian unit
// Watches the handshakes and the reset behavior seen at the top level.
// ----------------------------------------------------------------------------
module fjac_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fjac_pkg::out_beat_t out_beat_o
);

  // A stalled result beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_beat_o)))
    else $error("stalled result beat changed or dropped");

  // The input side only stalls when the output side is backing up.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // No result beat is shown in the cycle after reset was applied.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result beat valid after reset");

endmodule

bind fixed_point_constraint_jacobian_unit fjac_checker u_fjac_checker (.*);
